// ===== hw/rtl/ofc_pkg.sv =====
// ----------------------------------------------------------------------------
// ofc_pkg: shared types and constants
// Field widths, arithmetic constants and the payload carried along the
// divider chain of the frequency-to-code converter.
// ----------------------------------------------------------------------------
`default_nettype none

package ofc_pkg;

    localparam int FREQ_W = 16;              // request frequency in kHz
    localparam int CODE_W = 16;              // control word
    localparam int CFG_W  = 2;               // output config bits
    localparam int HZ_W   = 26;              // 65535 * 1000 < 2^26
    localparam int K_W    = 4;               // octave 0..15
    localparam int Q_W    = 12;              // quotient bits, N/F < 4096
    localparam int NUM_W  = 37;              // 2078 << 25 < 2^37
    localparam int DAC_W  = 10;
    localparam int SHIFT_W = 5;              // 10 + k <= 25

    localparam int HZ_PER_KHZ   = 1000;
    localparam int OCT_BASE_HZ  = 1039;
    localparam int DAC_NUM_BASE = 2078;
    localparam int DAC_SHIFT0   = 10;
    localparam int OCT_MAX      = 15;
    localparam int DAC_MAX      = 1023;
    localparam int DAC_CENTER   = 2048;
    localparam logic [FREQ_W-1:0] KHZ_SAT = '1;

    // corrected frequency in Hz, after the first stage
    typedef struct packed {
        logic [HZ_W-1:0] f;
    } prep_t;

    // state of one division in flight
    typedef struct packed {
        logic            zero;   // F == 0
        logic [K_W-1:0]  k;      // octave
        logic [HZ_W-1:0] f;      // divisor
        logic [HZ_W-1:0] rem;    // partial remainder, < f
        logic [Q_W-1:0]  nq;     // dividend bits still to shift in, quotient bits shifted out
    } div_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ofc_req_if.sv =====
// ----------------------------------------------------------------------------
// ofc_req_if: request channel
// valid/ready channel carrying one requested frequency in kHz.
// ----------------------------------------------------------------------------
`default_nettype none

interface ofc_req_if;
    import ofc_pkg::*;

    logic              valid;
    logic              ready;
    logic [FREQ_W-1:0] target_khz;

    modport source (output valid, output target_khz, input ready);
    modport sink   (input valid, input target_khz, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/ofc_rsp_if.sv =====
// ----------------------------------------------------------------------------
// ofc_rsp_if: response channel
// valid/ready channel carrying one 16-bit oscillator control word.
// ----------------------------------------------------------------------------
`default_nettype none

interface ofc_rsp_if;
    import ofc_pkg::*;

    logic              valid;
    logic              ready;
    logic [CODE_W-1:0] code;

    modport source (output valid, output code, input ready);
    modport sink   (input valid, input code, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/oscillator_freq_to_code_core.sv =====
// ----------------------------------------------------------------------------
// oscillator_freq_to_code_core: kHz request to oscillator control word
// Corrects the requested frequency, picks the octave and computes the
// 10-bit dac value with a chain of restoring-division cells.
// ----------------------------------------------------------------------------
//
//  channel  | dir | handshake        | payload
//  ---------+-----+------------------+-------------------------------------
//  req      | in  | valid / ready    | target_khz[15:0]
//  rsp      | out | valid / ready    | code[15:0] = octave, dac, out config
//  cfg      | in  | cfg_wr_en        | cfg_wr_data[1:0] -> code[1:0]
//
//  One request per cycle sustained while rsp is ready; 15 register stages
//  lie between request and response (correction/Hz, octave, 12 division
//  cells, one per quotient bit, rounding).
//  Each stage frees itself as soon as its neighbor takes the data, so
//  bubbles collapse under a response stall; req.ready drops only when all 15 are full.
//  Reset clears the valid bits and config register (0); config is captured at rounding.
// ----------------------------------------------------------------------------
`default_nettype none

module oscillator_freq_to_code_core (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    ofc_req_if.sink                        req,
    ofc_rsp_if.source                      rsp,
    input  wire logic                      cfg_wr_en,
    input  wire logic [ofc_pkg::CFG_W-1:0] cfg_wr_data
);
    import ofc_pkg::*;

    logic [CFG_W-1:0] cfg_reg;
    logic [CFG_W-1:0] cfg_next;

    // prep -> octave
    logic  prep_valid;
    logic  prep_ready;
    prep_t prep_data;

    // octave output is chain slot 0; cell i reads slot i, writes slot i+1
    logic  chain_valid [0:Q_W];
    logic  chain_ready [0:Q_W];
    div_t  chain_data  [0:Q_W];

    assign cfg_next = cfg_wr_en ? cfg_wr_data : cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    ofc_prep u_prep (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .dn_valid (prep_valid),
        .dn_ready (prep_ready),
        .dn_data  (prep_data)
    );

    ofc_octave u_octave (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (prep_valid),
        .up_ready (prep_ready),
        .up_data  (prep_data),
        .dn_valid (chain_valid[0]),
        .dn_ready (chain_ready[0]),
        .dn_data  (chain_data[0])
    );

    // one quotient bit per cell, most significant first
    for (genvar i = 0; i < Q_W; i++)
    begin : g_cell
        ofc_div_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (chain_valid[i]),
            .up_ready (chain_ready[i]),
            .up_data  (chain_data[i]),
            .dn_valid (chain_valid[i+1]),
            .dn_ready (chain_ready[i+1]),
            .dn_data  (chain_data[i+1])
        );
    end

    ofc_round u_round (
        .clk      (clk),
        .rst_n    (rst_n),
        .out_cfg  (cfg_reg),
        .up_valid (chain_valid[Q_W]),
        .up_ready (chain_ready[Q_W]),
        .up_data  (chain_data[Q_W]),
        .rsp      (rsp)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/ofc_prep.sv =====
// ----------------------------------------------------------------------------
// ofc_prep: input stage
// Stepped kHz correction with saturation, then conversion to Hz.
// ----------------------------------------------------------------------------
`default_nettype none

module ofc_prep (
    input  wire logic          clk,
    input  wire logic          rst_n,
    ofc_req_if.sink            req,
    output logic               dn_valid,
    input  wire logic          dn_ready,
    output ofc_pkg::prep_t     dn_data
);
    import ofc_pkg::*;

    logic              v_reg;
    logic              v_next;
    prep_t             d_reg;
    prep_t             d_next;
    logic [2:0]        add;
    logic [FREQ_W:0]   sum;
    logic [FREQ_W-1:0] khz_c;
    logic              up_ready;

    assign up_ready  = !v_reg || dn_ready;
    assign req.ready = up_ready;

    always_comb
    begin
        if (req.target_khz >= FREQ_W'(1000))     add = 3'd7;
        else if (req.target_khz >= FREQ_W'(833)) add = 3'd6;
        else if (req.target_khz >= FREQ_W'(666)) add = 3'd5;
        else if (req.target_khz >= FREQ_W'(500)) add = 3'd4;
        else if (req.target_khz >= FREQ_W'(366)) add = 3'd3;
        else if (req.target_khz >= FREQ_W'(233)) add = 3'd2;
        else if (req.target_khz >= FREQ_W'(100)) add = 3'd1;
        else                                     add = 3'd0;

        sum   = {1'b0, req.target_khz} + (FREQ_W+1)'(add);
        khz_c = sum[FREQ_W] ? KHZ_SAT : sum[FREQ_W-1:0];

        v_next = v_reg;
        d_next = d_reg;
        if (up_ready)
        begin
            v_next = req.valid;
            if (req.valid)
            begin
                d_next.f = HZ_W'({{(HZ_W-FREQ_W){1'b0}}, khz_c} * HZ_W'(HZ_PER_KHZ));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        d_reg <= d_next;
    end

    assign dn_valid = v_reg;
    assign dn_data  = d_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/ofc_octave.sv =====
// ----------------------------------------------------------------------------
// ofc_octave: octave select and dividend setup
// Picks the octave from the frequency and loads the divider chain.
// ----------------------------------------------------------------------------
`default_nettype none

module ofc_octave (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          up_valid,
    output logic               up_ready,
    input  wire ofc_pkg::prep_t up_data,
    output logic               dn_valid,
    input  wire logic          dn_ready,
    output ofc_pkg::div_t      dn_data
);
    import ofc_pkg::*;

    logic             v_reg;
    logic             v_next;
    div_t             d_reg;
    div_t             d_next;
    logic [K_W-1:0]   k;
    logic [NUM_W-1:0] num;

    assign up_ready = !v_reg || dn_ready;

    always_comb
    begin
        // thresholds rise with i, so the last hit is the largest octave
        k = '0;
        for (int i = 1; i <= OCT_MAX; i++)
        begin
            if ((HZ_W'(OCT_BASE_HZ) << i) <= up_data.f)
            begin
                k = K_W'(i);
            end
        end

        num = NUM_W'(DAC_NUM_BASE) << (SHIFT_W'(DAC_SHIFT0) + {1'b0, k});

        v_next = v_reg;
        d_next = d_reg;
        if (up_ready)
        begin
            v_next = up_valid;
            if (up_valid)
            begin
                d_next.zero = (up_data.f == '0);
                d_next.k    = k;
                d_next.f    = up_data.f;
                d_next.rem  = HZ_W'(num[NUM_W-1:Q_W]);
                d_next.nq   = num[Q_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        d_reg <= d_next;
    end

    assign dn_valid = v_reg;
    assign dn_data  = d_reg;

    // octave threshold is met whenever an octave above zero is chosen
    a_oct_floor: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg && (d_reg.k != '0) |-> (HZ_W'(OCT_BASE_HZ) << d_reg.k) <= d_reg.f)
        else $error("octave above frequency");

endmodule

`default_nettype wire

// ===== hw/rtl/ofc_div_cell.sv =====
// ----------------------------------------------------------------------------
// ofc_div_cell: one restoring-division cell
// Shifts one dividend bit into the remainder, trial-subtracts the divisor
// and shifts one quotient bit out toward the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module ofc_div_cell (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          up_valid,
    output logic               up_ready,
    input  wire ofc_pkg::div_t up_data,
    output logic               dn_valid,
    input  wire logic          dn_ready,
    output ofc_pkg::div_t      dn_data
);
    import ofc_pkg::*;

    logic            v_reg;
    logic            v_next;
    div_t            d_reg;
    div_t            d_next;
    logic [HZ_W:0]   trial;
    logic [HZ_W:0]   diff;
    logic            ge;

    assign up_ready = !v_reg || dn_ready;

    always_comb
    begin
        trial = {up_data.rem, up_data.nq[Q_W-1]};
        diff  = trial - {1'b0, up_data.f};
        ge    = (trial >= {1'b0, up_data.f});

        v_next = v_reg;
        d_next = d_reg;
        if (up_ready)
        begin
            v_next = up_valid;
            if (up_valid)
            begin
                d_next     = up_data;
                d_next.rem = ge ? diff[HZ_W-1:0] : trial[HZ_W-1:0];
                d_next.nq  = {up_data.nq[Q_W-2:0], ge};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        d_reg <= d_next;
    end

    assign dn_valid = v_reg;
    assign dn_data  = d_reg;

    // partial remainder stays below the divisor for any nonzero frequency
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg && !d_reg.zero |-> d_reg.rem < d_reg.f)
        else $error("remainder not below divisor");

endmodule

`default_nettype wire

// ===== hw/rtl/ofc_round.sv =====
// ----------------------------------------------------------------------------
// ofc_round: rounding, clamp and output register
// Rounds 2048 - N/F to nearest (halves down), clamps to the dac range and
// holds the packed control word for the response channel.
// ----------------------------------------------------------------------------
`default_nettype none

module ofc_round (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic [ofc_pkg::CFG_W-1:0] out_cfg,
    input  wire logic                    up_valid,
    output logic                         up_ready,
    input  wire ofc_pkg::div_t           up_data,
    ofc_rsp_if.source                    rsp
);
    import ofc_pkg::*;

    logic               v_reg;
    logic               v_next;
    logic [CODE_W-1:0]  code_reg;
    logic [CODE_W-1:0]  code_next;
    logic               round_dn;
    logic signed [Q_W+1:0] v;
    logic [DAC_W-1:0]   dac;

    assign up_ready = !v_reg || rsp.ready;

    always_comb
    begin
        round_dn = (up_data.rem == '0) || ({up_data.rem, 1'b0} < {1'b0, up_data.f});
        v = (Q_W+2)'(DAC_CENTER) - $signed({2'b00, up_data.nq});
        if (!round_dn)
        begin
            v = v - (Q_W+2)'(1);
        end

        if (up_data.zero || v < 0)         dac = '0;
        else if (v > (Q_W+2)'(DAC_MAX))    dac = DAC_W'(DAC_MAX);
        else                               dac = v[DAC_W-1:0];

        v_next    = v_reg;
        code_next = code_reg;
        if (up_ready)
        begin
            v_next = up_valid;
            if (up_valid)
            begin
                code_next = {up_data.k, dac, out_cfg};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        code_reg <= code_next;
    end

    assign rsp.valid = v_reg;
    assign rsp.code  = code_reg;

    // zero frequency leaves only the config bits
    a_zero_code: assert property (@(posedge clk) disable iff (!rst_n)
        up_valid && up_ready && up_data.zero |=> code_reg[CODE_W-1:CFG_W] == '0)
        else $error("zero frequency gave nonzero octave or dac");

endmodule

`default_nettype wire
